FILE: rtl/serial_line_assembler_queue_macros.svh
// ---------------------------------------------------------------------------
// serial line assembler queue assertion macros
// shared concurrent check wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SERIAL_LINE_ASSEMBLER_QUEUE_MACROS_SVH
`define SERIAL_LINE_ASSEMBLER_QUEUE_MACROS_SVH

`ifndef SYNTH
// property must hold on every rising clock edge out of reset
`define SLAQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define SLAQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLAQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLAQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/slaq_pkg.sv
// ---------------------------------------------------------------------------
// slaq_pkg
// shared constants, status codes and control structs of the line queue
// ---------------------------------------------------------------------------
package slaq_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LINE_LEN_DEF    = 64;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        ST_TAKEN     = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_DISCARDED = 3'd2,
        ST_FULL      = 3'd3,
        ST_CHAR      = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic pop_start;
        logic rd_issue;
        logic char_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic out_free;
        logic char_last;
    } t_dp_status;

endpackage

FILE: rtl/slaq_datapath.sv
// ---------------------------------------------------------------------------
// slaq_datapath
// line assembly, line memory, ring pointers and output beat register
// ---------------------------------------------------------------------------
`include "serial_line_assembler_queue_macros.svh"

module slaq_datapath #(
    parameter int QUEUE_DEPTH = slaq_pkg::QUEUE_DEPTH_DEF,
    parameter int LINE_LEN    = slaq_pkg::LINE_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slaq_pkg::t_ctrl_cmd  i_cmd,
    input  logic [7:0]           i_byte,
    input  logic                 i_out_ready,
    output slaq_pkg::t_dp_status o_sts,
    output logic                 o_out_valid,
    output logic [2:0]           o_out_status,
    output logic [7:0]           o_out_char,
    output logic                 o_out_last,
    output logic                 o_out_ack
);
    import slaq_pkg::*;

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W     = $clog2(LINE_LEN);
    localparam int MEM_DEPTH = QUEUE_DEPTH * LINE_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] LL_A      = ADDR_W'(LINE_LEN);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(LINE_LEN - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(QUEUE_DEPTH);

    logic [7:0]        r_line_store [MEM_DEPTH];
    logic [CNT_W-1:0]  r_line_len   [QUEUE_DEPTH];
    logic              r_ack_flag   [QUEUE_DEPTH];

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0]  r_char_cnt, n_char_cnt;
    logic              r_in_comment, n_in_comment;
    logic              r_esc, n_esc;
    logic              r_first_semi, n_first_semi;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [7:0]        r_rdata;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [7:0]        r_out_char;
    logic              r_out_last;
    logic              r_out_ack;

    t_status           byte_st;
    logic              byte_store;
    logic              mem_we;
    logic              len_we;
    logic              cnt_at_limit;
    logic              is_eol;
    logic              char_last;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign cnt_at_limit = (r_char_cnt >= CNT_LIMIT);
    assign is_eol       = (i_byte == CH_LF) || (i_byte == CH_CR);
    assign wr_addr      = ADDR_W'(r_wr_slot) * LL_A + ADDR_W'(r_char_cnt);
    assign rd_addr      = ADDR_W'(r_rd_slot) * LL_A + ADDR_W'(r_rd_idx);
    assign char_last    = ({1'b0, r_rd_idx} + 1'b1) == {1'b0, r_line_len[r_rd_slot]};

    // byte handling and ring bookkeeping
    always_comb begin
        n_fill       = r_fill;
        n_wr_slot    = r_wr_slot;
        n_rd_slot    = r_rd_slot;
        n_char_cnt   = r_char_cnt;
        n_in_comment = r_in_comment;
        n_esc        = r_esc;
        n_first_semi = r_first_semi;
        byte_st      = ST_TAKEN;
        byte_store   = 1'b0;
        mem_we       = 1'b0;
        len_we       = 1'b0;
        if (i_cmd.take_byte) begin
            if (r_fill == FILL_MAX) begin
                byte_st = ST_FULL;
            end else if (r_esc) begin
                n_esc      = 1'b0;
                byte_store = !r_in_comment;
            end else if (is_eol) begin
                n_in_comment = 1'b0;
                n_char_cnt   = '0;
                if ((r_char_cnt == '0) || r_first_semi) begin
                    byte_st = ST_DISCARDED;
                end else begin
                    byte_st   = ST_QUEUED;
                    len_we    = 1'b1;
                    n_wr_slot = (r_wr_slot == SLOT_LAST) ? '0 : r_wr_slot + 1'b1;
                    n_fill    = r_fill + 1'b1;
                end
            end else if (cnt_at_limit) begin
                byte_st = ST_TAKEN;
            end else if (i_byte == CH_BSLASH) begin
                n_esc = 1'b1;
            end else begin
                if (i_byte == CH_SEMI) begin
                    n_in_comment = 1'b1;
                end
                byte_store = !(r_in_comment || (i_byte == CH_SEMI));
            end
            if (byte_store && !cnt_at_limit) begin
                mem_we     = 1'b1;
                n_char_cnt = r_char_cnt + 1'b1;
                if (r_char_cnt == '0) begin
                    n_first_semi = (i_byte == CH_SEMI);
                end
            end
        end
        if (i_cmd.char_load && char_last) begin
            n_fill    = r_fill - 1'b1;
            n_rd_slot = (r_rd_slot == SLOT_LAST) ? '0 : r_rd_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_wr_slot    <= '0;
            r_rd_slot    <= '0;
            r_char_cnt   <= '0;
            r_in_comment <= 1'b0;
            r_esc        <= 1'b0;
            r_first_semi <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            r_fill       <= n_fill;
            r_wr_slot    <= n_wr_slot;
            r_rd_slot    <= n_rd_slot;
            r_char_cnt   <= n_char_cnt;
            r_in_comment <= n_in_comment;
            r_esc        <= n_esc;
            r_first_semi <= n_first_semi;
            if (i_cmd.pop_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.char_load) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // line memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_store[wr_addr] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rdata <= r_line_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_line_len[r_wr_slot] <= r_char_cnt;
            r_ack_flag[r_wr_slot] <= 1'b1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take_byte || (i_cmd.pop_start && (r_fill == '0))
                     || i_cmd.char_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_out_status <= byte_st;
            r_out_char   <= '0;
            r_out_last   <= 1'b0;
            r_out_ack    <= 1'b0;
        end else if (i_cmd.pop_start && (r_fill == '0)) begin
            r_out_status <= ST_EMPTY;
            r_out_char   <= '0;
            r_out_last   <= 1'b0;
            r_out_ack    <= 1'b0;
        end else if (i_cmd.char_load) begin
            r_out_status <= ST_CHAR;
            r_out_char   <= r_rdata;
            r_out_last   <= char_last;
            r_out_ack    <= r_ack_flag[r_rd_slot];
        end
    end

    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.char_last = char_last;
    assign o_out_valid     = r_out_valid;
    assign o_out_status    = r_out_status;
    assign o_out_char      = r_out_char;
    assign o_out_last      = r_out_last;
    assign o_out_ack       = r_out_ack;

    `SLAQ_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FILL_MAX, "queue fill beyond depth")
    `SLAQ_NEVER(a_store_limit, i_clk, i_rst_n, mem_we && cnt_at_limit, "store past line limit")
    `SLAQ_ASSERT(a_queue_inc, i_clk, i_rst_n, (i_cmd.take_byte && byte_st == ST_QUEUED) |=> (r_fill == $past(r_fill) + 1'b1), "queued line not counted")

endmodule

FILE: rtl/slaq_ctrl.sv
// ---------------------------------------------------------------------------
// slaq_ctrl
// sequencer for byte intake and character-by-character line pops
// ---------------------------------------------------------------------------
`include "serial_line_assembler_queue_macros.svh"

module slaq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_pop,
    input  slaq_pkg::t_dp_status i_sts,
    output logic                 o_in_ready,
    output slaq_pkg::t_ctrl_cmd  o_cmd
);
    import slaq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } t_state;

    t_state r_state, n_state;
    logic   in_ready;
    logic   in_beat;

    assign in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign in_beat  = i_in_valid && in_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.take_byte = 1'b0;
        o_cmd.pop_start = 1'b0;
        o_cmd.rd_issue  = 1'b0;
        o_cmd.char_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take_byte = in_beat && !i_in_pop;
                o_cmd.pop_start = in_beat && i_in_pop;
                if (in_beat && i_in_pop && !i_sts.fill_zero) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_WR;
            end
            S_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.char_load = 1'b1;
                    n_state         = i_sts.char_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;

    `SLAQ_ASSERT(a_rd_then_wr, i_clk, i_rst_n, (r_state == S_RD) |=> (r_state == S_WR), "read not followed by load")
    `SLAQ_ASSERT(a_last_to_idle, i_clk, i_rst_n, (o_cmd.char_load && i_sts.char_last) |=> (r_state == S_IDLE), "pop did not end on last char")
    `SLAQ_NEVER(a_no_intake_busy, i_clk, i_rst_n, (r_state != S_IDLE) && (o_cmd.take_byte || o_cmd.pop_start), "intake during pop")

endmodule

FILE: rtl/serial_line_assembler_queue.sv
// serial byte beat: its status beat appears the next cycle;
// one byte per cycle while no pop streams and the output beat is taken each cycle
// pop beat: an empty ring answers the next cycle; a queued line streams its chars,
// each read from the line memory into a register, loaded once the output is free
// reset: ring pointers, fill count and line parser cleared; line memory left as is
// ---------------------------------------------------------------------------
// serial_line_assembler_queue
// assembles serial bytes into command lines and queues them in a ring
// ---------------------------------------------------------------------------
module serial_line_assembler_queue #(
    parameter int QUEUE_DEPTH = slaq_pkg::QUEUE_DEPTH_DEF,
    parameter int LINE_LEN    = slaq_pkg::LINE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command: 0 byte, 1 pop
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] line_char, [8] ack_wanted, [15:9] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast    // last_char
);
    import slaq_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic [7:0] out_char;
    logic       out_ack;

    // sequencer: decides when a beat is taken and walks popped lines
    slaq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_pop   (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // parser state, line memory, ring and the output beat register
    slaq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LINE_LEN    (LINE_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_byte       (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_char   (out_char),
        .o_out_last   (m_axis_tlast),
        .o_out_ack    (out_ack)
    );

    // pack result fields, lowest bit first, padded to two bytes
    assign m_axis_tdata = {7'd0, out_ack, out_char};

endmodule
